FILE: design/tvg_pkg.sv
// Shared types, raster constants and the character ROM for the text video generator.
// No dependencies; every other file of the block imports this package.
package tvg_pkg;

  // Screen memory geometry
  localparam int unsigned SCREEN_BYTES = 1024;
  localparam int unsigned ADDR_W       = 10;
  localparam int unsigned CODE_W       = 8;
  localparam int unsigned POS_W        = 9;
  localparam int unsigned SUM_W        = 11;

  // Raster timing
  localparam logic [POS_W-1:0] DOT_LAST     = 9'd454;
  localparam logic [POS_W-1:0] LINE_LAST    = 9'd261;
  localparam logic [POS_W-1:0] ACTIVE_DOTS  = 9'd280;
  localparam logic [POS_W-1:0] ACTIVE_LINES = 9'd192;
  localparam logic [POS_W-1:0] HSYNC_FIRST  = 9'd290;
  localparam logic [POS_W-1:0] HSYNC_END    = 9'd340;
  localparam logic [POS_W-1:0] VSYNC_FIRST  = 9'd220;
  localparam logic [POS_W-1:0] VSYNC_END    = 9'd224;
  localparam logic [2:0]       CELL_DOT_LAST  = 3'd6;
  localparam logic [2:0]       CELL_LINE_LAST = 3'd7;

  // Character codes
  localparam logic [CODE_W-1:0] CODE_SPACE = 8'h20;
  localparam logic [CODE_W-1:0] CODE_A     = 8'h41;
  localparam logic [CODE_W-1:0] CODE_F     = 8'h46;

  typedef enum logic {
    OP_TICK  = 1'b0,
    OP_WRITE = 1'b1
  } op_e;

  typedef enum logic {
    CLR_SWEEP = 1'b0,
    CLR_DONE  = 1'b1
  } clr_state_e;

  // Raster position info handed from the timing unit to the renderer
  typedef struct packed {
    logic [2:0] cell_dot;
    logic [2:0] cell_line;
    logic       cell_ok;
    logic       hsync;
    logic       vsync;
    logic       hblank;
    logic       vblank;
  } pos_t;

  // Glyph rows for 'A'..'F'; the two spare rows are never selected
  localparam logic [7:0] GLYPH_ROWS [8][8] = '{
    '{8'h18, 8'h24, 8'h42, 8'h7e, 8'h42, 8'h42, 8'h42, 8'h00},
    '{8'h7c, 8'h42, 8'h42, 8'h7c, 8'h42, 8'h42, 8'h7c, 8'h00},
    '{8'h3c, 8'h42, 8'h40, 8'h40, 8'h40, 8'h42, 8'h3c, 8'h00},
    '{8'h78, 8'h44, 8'h42, 8'h42, 8'h42, 8'h44, 8'h78, 8'h00},
    '{8'h7e, 8'h40, 8'h40, 8'h78, 8'h40, 8'h40, 8'h7e, 8'h00},
    '{8'h7e, 8'h40, 8'h40, 8'h78, 8'h40, 8'h40, 8'h40, 8'h00},
    '{8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
    '{8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00}
  };

  // Dot value of a code at a cell dot and cell line
  function automatic logic glyph_dot(logic [CODE_W-1:0] code, logic [2:0] dot,
                                     logic [2:0] line);
    logic [CODE_W-1:0] idx;
    logic [7:0]        bits;
    logic              lit;
    idx  = code - CODE_A;
    bits = GLYPH_ROWS[idx[2:0]][line];
    if (code == CODE_SPACE) begin
      lit = 1'b0;
    end else if (code >= CODE_A && code <= CODE_F) begin
      lit = bits[3'd7 - dot];
    end else begin
      // filled block for unmapped codes
      lit = (line > 3'd0) && (line < 3'd7) && (dot > 3'd0) && (dot < 3'd6);
    end
    return lit;
  endfunction

endpackage

FILE: design/tvg_if.sv
// Handshake channels of the text video generator: command input and video output.
// Depends on tvg_pkg for field widths.
interface tvg_in_if import tvg_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              operation;
  logic [ADDR_W-1:0] write_address;
  logic [CODE_W-1:0] write_data;

  modport source (output valid, output operation, output write_address,
                  output write_data, input ready);
  modport sink (input valid, input operation, input write_address,
                input write_data, output ready);
endinterface

interface tvg_out_if import tvg_pkg::*; ();
  logic valid;
  logic ready;
  logic pixel;
  logic hsync;
  logic vsync;
  logic hblank;
  logic vblank;

  modport source (output valid, output pixel, output hsync, output vsync,
                  output hblank, output vblank, input ready);
  modport sink (input valid, input pixel, input hsync, input vsync,
                input hblank, input vblank, output ready);
endinterface

FILE: design/text_mode_video_generator_top.sv
// Top level of the 40x24 text video generator: timing, screen memory, renderer.
// Depends on tvg_pkg, tvg_if, tvg_timing, tvg_screen_ram and tvg_render.
//
//   channel  dir  transaction                                  results
//   in_i     in   operation, write_address, write_data         tick: one, write: none
//   out_o    out  pixel, hsync, vsync, hblank, vblank          one per tick
//
// One transaction a cycle in sustained flow; the screen memory takes one write or one
// read per cycle and the counters advance in the accepting cycle.
// A tick's result is formed after acceptance by the memory read register, then the glyph
// lookup into the output register.
// After reset a clearing pass fills the 1024 screen bytes with spaces, one a cycle,
// with ready low throughout the pass.
// A stalled output holds one result in the output register and one in the fetch
// stage; outside the clearing pass, ready drops only when both are full and out_o.ready is low.
module text_mode_video_generator_top import tvg_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  tvg_in_if.sink    in_i,
  tvg_out_if.source out_o
);

  logic              ram_busy, can_take, accept, tick, write;
  pos_t              pos;
  logic [ADDR_W-1:0] cell_addr;
  logic [CODE_W-1:0] code;

  // Take a transaction when the memory is out of its sweep and the renderer has room
  assign in_i.ready = !ram_busy && can_take;
  assign accept     = in_i.valid && in_i.ready;
  assign tick       = accept && (in_i.operation == OP_TICK);
  assign write      = accept && (in_i.operation == OP_WRITE);

  tvg_timing u_timing (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .advance_i   (tick),
    .pos_o       (pos),
    .cell_addr_o (cell_addr)
  );

  tvg_screen_ram u_ram (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_en_i   (write),
    .wr_addr_i (in_i.write_address),
    .wr_data_i (in_i.write_data),
    .rd_en_i   (tick),
    .rd_addr_i (cell_addr),
    .rd_data_o (code),
    .busy_o    (ram_busy)
  );

  tvg_render u_render (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .tick_i     (tick),
    .pos_i      (pos),
    .code_i     (code),
    .can_take_o (can_take),
    .out_o      (out_o)
  );

endmodule

FILE: design/tvg_timing.sv
// Raster counters: dot, line and cell position, sync/blank flags, cell address.
// Depends on tvg_pkg.
module tvg_timing import tvg_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              advance_i,
  output pos_t              pos_o,
  output logic [ADDR_W-1:0] cell_addr_o
);

  logic [POS_W-1:0] dot_q, dot_d, line_q, line_d;
  logic [2:0]       cell_dot_q, cell_dot_d, cell_line_q, cell_line_d;
  logic [6:0]       col_q, col_d;
  logic [5:0]       row_q, row_d;
  logic [SUM_W-1:0] cell_sum;

  // Advance the counters by one dot
  always_comb begin
    dot_d       = dot_q;
    line_d      = line_q;
    cell_dot_d  = cell_dot_q;
    cell_line_d = cell_line_q;
    col_d       = col_q;
    row_d       = row_q;
    if (advance_i) begin
      if (dot_q == DOT_LAST) begin
        dot_d      = '0;
        cell_dot_d = '0;
        col_d      = '0;
        if (line_q == LINE_LAST) begin
          line_d      = '0;
          cell_line_d = '0;
          row_d       = '0;
        end else begin
          line_d = line_q + 9'd1;
          if (cell_line_q == CELL_LINE_LAST) begin
            cell_line_d = '0;
            row_d       = row_q + 6'd1;
          end else begin
            cell_line_d = cell_line_q + 3'd1;
          end
        end
      end else begin
        dot_d = dot_q + 9'd1;
        if (cell_dot_q == CELL_DOT_LAST) begin
          cell_dot_d = '0;
          col_d      = col_q + 7'd1;
        end else begin
          cell_dot_d = cell_dot_q + 3'd1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dot_q       <= '0;
      line_q      <= '0;
      cell_dot_q  <= '0;
      cell_line_q <= '0;
      col_q       <= '0;
      row_q       <= '0;
    end else begin
      dot_q       <= dot_d;
      line_q      <= line_d;
      cell_dot_q  <= cell_dot_d;
      cell_line_q <= cell_line_d;
      col_q       <= col_d;
      row_q       <= row_d;
    end
  end

  // Cell address row*40 + column as row*32 + row*8 + column
  assign cell_sum = {row_q, 5'b0} + {2'b0, row_q, 3'b0} + {4'b0, col_q};
  assign cell_addr_o = cell_sum[ADDR_W-1:0];

  always_comb begin
    pos_o.cell_dot  = cell_dot_q;
    pos_o.cell_line = cell_line_q;
    pos_o.hblank    = dot_q >= ACTIVE_DOTS;
    pos_o.vblank    = line_q >= ACTIVE_LINES;
    pos_o.hsync     = (dot_q >= HSYNC_FIRST) && (dot_q < HSYNC_END);
    pos_o.vsync     = (line_q >= VSYNC_FIRST) && (line_q < VSYNC_END);
    pos_o.cell_ok   = !pos_o.hblank && !pos_o.vblank &&
                      (cell_sum < SUM_W'(SCREEN_BYTES));
  end

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !advance_i |=> $stable(dot_q) && $stable(line_q))
    else $error("raster counters moved without a tick");

  a_wrap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance_i && dot_q == DOT_LAST |=> dot_q == '0 && cell_dot_q == '0 && col_q == '0)
    else $error("line wrap did not clear the dot counters");

  a_cell_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    line_q == '0 |-> cell_line_q == '0 && row_q == '0)
    else $error("cell line counters out of step at frame start");

endmodule

FILE: design/tvg_screen_ram.sv
// Screen memory: one write port, one registered read port, clearing pass after reset.
// Depends on tvg_pkg.
module tvg_screen_ram import tvg_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              wr_en_i,
  input  logic [ADDR_W-1:0] wr_addr_i,
  input  logic [CODE_W-1:0] wr_data_i,
  input  logic              rd_en_i,
  input  logic [ADDR_W-1:0] rd_addr_i,
  output logic [CODE_W-1:0] rd_data_o,
  output logic              busy_o
);

  logic [CODE_W-1:0] mem [SCREEN_BYTES];
  logic [CODE_W-1:0] rd_data_q;
  clr_state_e        state_q, state_d;
  logic [ADDR_W-1:0] clr_addr_q, clr_addr_d;
  logic              we;
  logic [ADDR_W-1:0] waddr;
  logic [CODE_W-1:0] wdata;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= CLR_SWEEP;
      clr_addr_q <= '0;
    end else begin
      state_q    <= state_d;
      clr_addr_q <= clr_addr_d;
    end
  end

  // Sweep spaces through every entry, then hand the port to the datapath
  always_comb begin
    state_d    = state_q;
    clr_addr_d = clr_addr_q;
    busy_o     = 1'b0;
    we         = 1'b0;
    waddr      = wr_addr_i;
    wdata      = wr_data_i;
    case (state_q)
      CLR_SWEEP: begin
        busy_o     = 1'b1;
        we         = 1'b1;
        waddr      = clr_addr_q;
        wdata      = CODE_SPACE;
        clr_addr_d = clr_addr_q + ADDR_W'(1);
        if (clr_addr_q == ADDR_W'(SCREEN_BYTES - 1)) begin
          state_d = CLR_DONE;
        end
      end
      CLR_DONE: begin
        we = wr_en_i && ({1'b0, wr_addr_i} < (ADDR_W + 1)'(SCREEN_BYTES));
      end
      default: begin
        state_d = CLR_SWEEP;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (rd_en_i) begin
      rd_data_q <= mem[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

  a_no_access_in_sweep: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == CLR_SWEEP |-> !rd_en_i && !wr_en_i)
    else $error("screen memory accessed during clearing pass");

endmodule

FILE: design/tvg_render.sv
// Pixel stage and output register: glyph lookup on the fetched code, output skid.
// Depends on tvg_pkg and tvg_out_if.
module tvg_render import tvg_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              tick_i,
  input  pos_t              pos_i,
  input  logic [CODE_W-1:0] code_i,
  output logic              can_take_o,
  tvg_out_if.source         out_o
);

  logic s1_valid_q, s1_valid_d;
  pos_t s1_pos_q;
  logic out_valid_q, out_valid_d;
  logic pixel_q, hsync_q, vsync_q, hblank_q, vblank_q;
  logic out_free, s1_move, px;

  assign out_free   = !out_valid_q || out_o.ready;
  assign s1_move    = s1_valid_q && out_free;
  assign can_take_o = !s1_valid_q || out_free;

  // Hold the fetch stage until the output register frees up; load or empty the output register
  always_comb begin
    s1_valid_d = s1_valid_q;
    if (can_take_o) begin
      s1_valid_d = tick_i;
    end
    out_valid_d = out_valid_q;
    if (s1_move) begin
      out_valid_d = 1'b1;
    end else if (out_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  assign px = s1_pos_q.cell_ok &&
              glyph_dot(code_i, s1_pos_q.cell_dot, s1_pos_q.cell_line);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (tick_i && can_take_o) begin
      s1_pos_q <= pos_i;
    end
    if (s1_move) begin
      pixel_q  <= px;
      hsync_q  <= s1_pos_q.hsync;
      vsync_q  <= s1_pos_q.vsync;
      hblank_q <= s1_pos_q.hblank;
      vblank_q <= s1_pos_q.vblank;
    end
  end

  assign out_o.valid  = out_valid_q;
  assign out_o.pixel  = pixel_q;
  assign out_o.hsync  = hsync_q;
  assign out_o.vsync  = vsync_q;
  assign out_o.hblank = hblank_q;
  assign out_o.vblank = vblank_q;

  a_dark_in_blank: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && (hblank_q || vblank_q) |-> !pixel_q)
    else $error("lit pixel during blanking");

  a_stage_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q && !out_free |=> s1_valid_q && $stable(s1_pos_q))
    else $error("fetch stage dropped while output stalled");

  a_no_take_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    tick_i |-> can_take_o)
    else $error("tick issued while renderer full");

endmodule

FILE: sim/tvg_checker.sv
// Scoreboard for the text video generator: predicts each tick's video result and compares.
// Depends on tvg_pkg for widths, raster constants and glyph rows, and on tvg_if.
module tvg_checker import tvg_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  tvg_in_if           in_i,
  tvg_out_if          out_i,
  output int unsigned mismatch_count_o,
  output int unsigned pending_o
);

  localparam int unsigned DOTS_PER_CELL  = 7;
  localparam int unsigned LINES_PER_CELL = 8;
  localparam int unsigned TEXT_COLS      = 40;
  localparam int unsigned REPORT_LIMIT   = 40;

  typedef struct packed {
    logic pixel;
    logic hsync;
    logic vsync;
    logic hblank;
    logic vblank;
  } video_t;

  logic [CODE_W-1:0] screen_mem [SCREEN_BYTES];
  logic [POS_W-1:0]  dot_pos;
  logic [POS_W-1:0]  line_pos;
  video_t            video_exp_q [$];
  int unsigned       mismatch_count = 0;
  int unsigned       results_seen   = 0;

  assign mismatch_count_o = mismatch_count;

  // Print one line per mismatch (first few only) and count every one
  task automatic report_mismatch(string msg);
    if (mismatch_count < REPORT_LIMIT) begin
      $display("[%0t] mismatch on video result %0d: %s", $time, results_seen, msg);
    end
    mismatch_count++;
  endtask

  // Lit state of one dot of a character cell
  function automatic logic char_dot_lit(logic [CODE_W-1:0] code, int unsigned cdot,
                                        int unsigned cline);
    logic [7:0] row;
    if (code == CODE_SPACE) begin
      return 1'b0;
    end
    if (code >= CODE_A && code <= CODE_F) begin
      row = GLYPH_ROWS[int'(code - CODE_A)][cline];
      return row[7 - cdot];
    end
    // anything else draws a solid block inset by one dot
    return (cline >= 1 && cline <= 6 && cdot >= 1 && cdot <= 5);
  endfunction

  // Video result for the current raster position
  function automatic video_t raster_video(logic [POS_W-1:0] dot, logic [POS_W-1:0] line);
    video_t      v;
    int unsigned cell_index;
    v.hblank   = (dot >= ACTIVE_DOTS);
    v.vblank   = (line >= ACTIVE_LINES);
    v.hsync    = (dot >= HSYNC_FIRST) && (dot < HSYNC_END);
    v.vsync    = (line >= VSYNC_FIRST) && (line < VSYNC_END);
    v.pixel    = 1'b0;
    cell_index = (int'(line) / LINES_PER_CELL) * TEXT_COLS + int'(dot) / DOTS_PER_CELL;
    if (!v.hblank && !v.vblank && cell_index < SCREEN_BYTES) begin
      v.pixel = char_dot_lit(screen_mem[cell_index], int'(dot) % DOTS_PER_CELL,
                             int'(line) % LINES_PER_CELL);
    end
    return v;
  endfunction

  // Compare output transactions first, then apply the input transaction of the same edge
  always @(posedge clk_i or negedge rst_ni) begin
    video_t seen;
    video_t want;
    if (!rst_ni) begin
      dot_pos  = '0;
      line_pos = '0;
      foreach (screen_mem[i]) screen_mem[i] = CODE_SPACE;
      video_exp_q.delete();
    end else begin
      if (out_i.valid && out_i.ready) begin
        seen.pixel  = out_i.pixel;
        seen.hsync  = out_i.hsync;
        seen.vsync  = out_i.vsync;
        seen.hblank = out_i.hblank;
        seen.vblank = out_i.vblank;
        if (video_exp_q.size() == 0) begin
          report_mismatch("result arrived with nothing expected");
        end else begin
          want = video_exp_q.pop_front();
          if (seen.pixel !== want.pixel)
            report_mismatch($sformatf("pixel %b, expected %b", seen.pixel, want.pixel));
          if (seen.hsync !== want.hsync)
            report_mismatch($sformatf("hsync %b, expected %b", seen.hsync, want.hsync));
          if (seen.vsync !== want.vsync)
            report_mismatch($sformatf("vsync %b, expected %b", seen.vsync, want.vsync));
          if (seen.hblank !== want.hblank)
            report_mismatch($sformatf("hblank %b, expected %b", seen.hblank, want.hblank));
          if (seen.vblank !== want.vblank)
            report_mismatch($sformatf("vblank %b, expected %b", seen.vblank, want.vblank));
        end
        results_seen++;
      end
      if (in_i.valid && in_i.ready) begin
        if (op_e'(in_i.operation) == OP_WRITE) begin
          if (in_i.write_address < SCREEN_BYTES) begin
            screen_mem[in_i.write_address] = in_i.write_data;
          end
        end else begin
          video_exp_q.push_back(raster_video(dot_pos, line_pos));
          // advance the raster position
          if (dot_pos == DOT_LAST) begin
            dot_pos  = '0;
            line_pos = (line_pos == LINE_LAST) ? '0 : line_pos + 1'b1;
          end else begin
            dot_pos = dot_pos + 1'b1;
          end
        end
      end
    end
    pending_o <= video_exp_q.size();
  end

endmodule

FILE: sim/tb_top.sv
// Testbench top for the text video generator: clock, reset, stimulus, receiver and verdict.
// Depends on tvg_pkg, tvg_if, the generator top level and tvg_checker.
module tb_top;
  import tvg_pkg::*;

  typedef enum logic [1:0] {
    IDLE_NORMAL,
    IDLE_NONE
  } idle_mode_e;

  localparam int unsigned RANDOM_ITEMS  = 530;
  localparam int unsigned VISIBLE_CELLS = 960;
  localparam int unsigned LONG_HOLD     = 64;
  localparam int unsigned DRAIN_LIMIT   = 20000;
  localparam int unsigned SETTLE_CYCLES = 16;

  logic        clk_i = 1'b0;
  logic        rst_ni;
  int unsigned mismatches;
  int unsigned pending;
  idle_mode_e  idle_mode   = IDLE_NORMAL;
  logic        hold_req    = 1'b0;
  int unsigned writes_sent = 0;
  int unsigned ticks_sent  = 0;

  tvg_in_if  cmd_ch ();
  tvg_out_if video_ch ();

  text_mode_video_generator_top u_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (cmd_ch),
    .out_o  (video_ch)
  );

  tvg_checker u_chk (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_i             (cmd_ch),
    .out_i            (video_ch),
    .mismatch_count_o (mismatches),
    .pending_o        (pending)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Gap length: none in IDLE_NONE mode; otherwise mostly none, some short, a few long
  function automatic int unsigned gap_len(idle_mode_e mode);
    int unsigned r;
    r = $urandom_range(0, 99);
    case (mode)
      IDLE_NONE: return 0;
      default: begin
        if (r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 30);
      end
    endcase
  endfunction

  // Character codes weighted toward space and the drawn glyphs, with boundary codes
  function automatic logic [CODE_W-1:0] pick_code();
    logic [CODE_W-1:0] border_codes [8] = '{8'h00, 8'h1f, 8'h21, 8'h40, 8'h47, 8'h7f,
                                            8'h80, 8'hff};
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 25) return CODE_SPACE;
    if (r < 65) return CODE_A + CODE_W'($urandom_range(0, 5));
    if (r < 85) return CODE_W'($urandom_range(0, 255));
    return border_codes[$urandom_range(0, 7)];
  endfunction

  // Drive one transaction and hold it until accepted
  task automatic send_item(op_e op, logic [ADDR_W-1:0] addr, logic [CODE_W-1:0] code);
    cmd_ch.valid         <= 1'b1;
    cmd_ch.operation     <= op;
    cmd_ch.write_address <= addr;
    cmd_ch.write_data    <= code;
    @(posedge clk_i);
    while (cmd_ch.ready !== 1'b1) @(posedge clk_i);
    if (op == OP_WRITE) writes_sent++;
    else ticks_sent++;
  endtask

  // Tick with junk in the unused fields
  task automatic send_tick();
    send_item(OP_TICK, ADDR_W'($urandom), CODE_W'($urandom));
  endtask

  task automatic pause_sender(int unsigned n);
    if (n > 0) begin
      cmd_ch.valid <= 1'b0;
      repeat (n) @(posedge clk_i);
    end
  endtask

  // Stop sending and wait for every outstanding result, bounded
  task automatic wait_results_drained();
    int unsigned waited;
    waited = 0;
    cmd_ch.valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk_i);
      waited++;
    end
  endtask

  // Receiver: random stalls, plus one long hold-off on request
  initial begin
    int unsigned stall_left;
    stall_left = 0;
    video_ch.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        hold_req   = 1'b0;
        stall_left = LONG_HOLD;
      end else if (stall_left == 0) begin
        stall_left = gap_len(idle_mode);
      end
      if (stall_left > 0) begin
        video_ch.ready <= 1'b0;
        stall_left--;
      end else begin
        video_ch.ready <= 1'b1;
      end
    end
  end

  // Stimulus and verdict
  initial begin
    int unsigned r;
    rst_ni = 1'b0;
    cmd_ch.valid         <= 1'b0;
    cmd_ch.operation     <= OP_TICK;
    cmd_ch.write_address <= '0;
    cmd_ch.write_data    <= '0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed: glyphs, block codes, address extremes, ignored tick fields
    send_item(OP_WRITE, ADDR_W'(0), CODE_A);
    send_item(OP_WRITE, ADDR_W'(1), CODE_F);
    send_item(OP_WRITE, ADDR_W'(2), 8'h80);
    send_item(OP_WRITE, ADDR_W'(3), 8'hff);
    send_item(OP_WRITE, ADDR_W'(4), 8'h00);
    send_item(OP_WRITE, ADDR_W'(5), 8'h47);
    send_item(OP_WRITE, ADDR_W'(6), 8'h40);
    send_item(OP_WRITE, ADDR_W'(VISIBLE_CELLS - 1), 8'h80);
    send_item(OP_WRITE, ADDR_W'(VISIBLE_CELLS), CODE_A);
    send_item(OP_WRITE, '1, 8'hff);
    send_item(OP_TICK, '1, '1);
    repeat (13) send_tick();

    // Random mix; hold off the receiver once and drain once
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      idle_mode = (i >= 400 && i < 480) ? IDLE_NONE : IDLE_NORMAL;
      if (i == 150) hold_req = 1'b1;
      if (i == 300) wait_results_drained();
      r = $urandom_range(0, 99);
      if (i >= 150 && i < 180) begin
        // keep offering ticks so the block backs up
        send_tick();
      end else begin
        if (r < 25) begin
          send_item(OP_WRITE,
                    ($urandom_range(0, 3) != 0) ? ADDR_W'($urandom_range(0, VISIBLE_CELLS - 1))
                                                : ADDR_W'($urandom),
                    pick_code());
        end else begin
          send_tick();
        end
        pause_sender(gap_len(idle_mode));
      end
    end

    wait_results_drained();
    repeat (SETTLE_CYCLES) @(posedge clk_i);

    $display("Run covered %0d screen writes and %0d dot ticks along the first raster line.",
             writes_sent, ticks_sent);
    $display("Output was held off for %0d cycles once and the sender drained once mid-run.",
             LONG_HOLD);
    if (pending != 0) $display("%0d expected results never arrived", pending);
    if (mismatches == 0 && pending == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #2_000_000;
    $display("Timeout: transactions stopped flowing");
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
